// ===== rtl/pbqm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbqm_pkg
// Shared types and constants of the plug bounce quirk monitor.
// ----------------------------------------------------------------------------
package pbqm_pkg;

    localparam int CFG_W   = 32;
    localparam int LEVEL_W = 4;
    localparam int COUNT_W = 4;

    localparam logic [2:0] STOP_NONE  = 3'b000;
    localparam logic [2:0] STOP_PROTO = 3'b011;
    localparam logic [2:0] STOP_ALL   = 3'b111;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic [31:0]        RST_ABNORMAL = 32'd1000;
    localparam logic [31:0]        RST_KEEP     = 32'd20000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_1  = 4'd1;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_2  = 4'd2;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_3  = 4'd3;
    localparam logic [3:0]         RST_RETRY    = 4'd3;

    typedef enum logic [2:0] {
        CFG_QUIRKS    = 3'd0,
        CFG_ADSP_PHY  = 3'd1,
        CFG_ABNORMAL  = 3'd2,
        CFG_KEEP      = 3'd3,
        CFG_LEVEL_1   = 3'd4,
        CFG_LEVEL_2   = 3'd5,
        CFG_LEVEL_3   = 3'd6,
        CFG_RETRY     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FB_LEAVE = 2'd0,
        FB_CLEAR = 2'd1,
        FB_FORCE = 2'd2
    } t_fallback;

    typedef enum logic [1:0] {
        PHY_NONE = 2'd0,
        PHY_ON   = 2'd1,
        PHY_OFF  = 2'd2
    } t_phy;

    typedef enum logic {
        REQ_PLUG  = 1'b0,
        REQ_TIMER = 1'b1
    } t_req;

    typedef struct packed {
        logic        req_type;
        logic        plugged;
        logic        cc_attached;
        logic        mmi_enabled;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic               link_hold;
        logic [2:0]         stop_flags;
        t_fallback          fallback_action;
        logic               clear_history;
        t_phy               phy_action;
        logic               arm_timer;
        logic               hold_awake;
        logic [COUNT_W-1:0] bounce_count;
        logic               report_error;
        logic               notify_battery;
        logic               ignored;
    } t_out_item;

    // update applied to the record cells when an event commits
    typedef struct packed {
        logic wr;
        logic mark;
        logic clr;
    } t_cell_cmd;

endpackage

// ===== rtl/pbqm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbqm_cell
// One plug record: plug-out time, valid bit and bounce mark, plus one stage
// of the counting chain that passes a partial count to the next cell.
// ----------------------------------------------------------------------------
module pbqm_cell #(
    parameter int RECORDS   = 8,
    parameter int TIME_BITS = 32,
    parameter int IDX       = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pbqm_pkg::t_cell_cmd            i_cmd,
    input  logic [$clog2(RECORDS)-1:0]     i_pos,
    input  logic [TIME_BITS-1:0]           i_ref,
    input  logic [TIME_BITS-1:0]           i_now,
    input  logic [$clog2(RECORDS+1)-1:0]   i_sum,
    output logic [$clog2(RECORDS+1)-1:0]   o_sum
);
    import pbqm_pkg::*;

    localparam int POS_W = $clog2(RECORDS);
    localparam int CNT_W = $clog2(RECORDS + 1);
    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [TIME_BITS-1:0] r_time;
    logic                 r_valid;
    logic                 r_mark;
    logic                 r_hit;
    logic [CNT_W-1:0]     r_sum;
    logic [TIME_BITS-1:0] diff;
    logic                 sel;

    // record time inside the window when ref - time wraps negative
    assign diff = i_ref - r_time;
    assign sel  = (i_pos == MY_POS);

    always_ff @(posedge i_clk) begin
        r_hit <= r_valid & diff[TIME_BITS-1];
        r_sum <= i_sum + CNT_W'(r_hit & r_mark);
        if (i_cmd.wr && sel) begin
            r_time <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mark  <= 1'b0;
        end else begin
            if (i_cmd.wr && sel) begin
                r_valid <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_mark <= 1'b0;
            end else if (i_cmd.mark && sel && r_hit) begin
                r_mark <= 1'b1;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/pbqm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbqm_ctrl
// Event sequencer: configuration registers, link and escalation state,
// chain timing and the registered result.
// ----------------------------------------------------------------------------
module pbqm_ctrl #(
    parameter int RECORDS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_idx,
    input  logic [pbqm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pbqm_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pbqm_pkg::t_out_item            o_out_item,
    input  logic [$clog2(RECORDS+1)-1:0]   i_chain_sum,
    output logic [TIME_BITS-1:0]           o_ref,
    output logic [TIME_BITS-1:0]           o_now,
    output pbqm_pkg::t_cell_cmd            o_cmd,
    output logic [$clog2(RECORDS)-1:0]     o_pos
);
    import pbqm_pkg::*;

    localparam int POS_W  = $clog2(RECORDS);
    localparam int CNT_W  = $clog2(RECORDS + 1);
    localparam int STEP_W = $clog2(RECORDS + 2);
    localparam int CMP_W  = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RECORDS + 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(RECORDS - 1);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    // configuration
    logic                 r_quirks;
    logic                 r_adsp;
    logic [31:0]          r_abnormal;
    logic [31:0]          r_keep_win;
    logic [LEVEL_W-1:0]   r_level_1;
    logic [LEVEL_W-1:0]   r_level_2;
    logic [LEVEL_W-1:0]   r_level_3;
    logic [3:0]           r_retry_lim;

    // control state
    t_state               r_state;
    logic [STEP_W-1:0]    r_step;
    t_in_item             r_in;
    logic [TIME_BITS-1:0] r_ref;
    logic [POS_W-1:0]     r_ring;
    logic                 r_last_seen;
    logic                 r_last_plug;
    logic                 r_link;
    logic                 r_keep;
    logic [3:0]           r_retry;
    logic [2:0]           r_stop;
    logic                 r_out_valid;
    t_out_item            r_out;

    // next values at commit
    logic [POS_W-1:0]     n_ring;
    logic                 n_last_seen;
    logic                 n_last_plug;
    logic                 n_link;
    logic                 n_keep;
    logic [3:0]           n_retry;
    logic [2:0]           n_stop;
    t_out_item            n_out;
    t_cell_cmd            n_cmd;

    logic                 in_xfer;
    logic                 commit;
    logic [31:0]          span;
    logic [CMP_W-1:0]     cnt;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_EVAL) && (r_step == LAST_STEP)
                        && (!r_out_valid || i_out_ready);
    assign span       = i_in_item.plugged ? r_abnormal : r_keep_win;
    assign cnt        = r_quirks ? CMP_W'(i_chain_sum) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quirks    <= 1'b0;
            r_adsp      <= 1'b0;
            r_abnormal  <= RST_ABNORMAL;
            r_keep_win  <= RST_KEEP;
            r_level_1   <= RST_LEVEL_1;
            r_level_2   <= RST_LEVEL_2;
            r_level_3   <= RST_LEVEL_3;
            r_retry_lim <= RST_RETRY;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_QUIRKS:   r_quirks    <= i_cfg_data[0];
                CFG_ADSP_PHY: r_adsp      <= i_cfg_data[0];
                CFG_ABNORMAL: r_abnormal  <= i_cfg_data[31:0];
                CFG_KEEP:     r_keep_win  <= i_cfg_data[31:0];
                CFG_LEVEL_1:  r_level_1   <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_2:  r_level_2   <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_3:  r_level_3   <= i_cfg_data[LEVEL_W-1:0];
                CFG_RETRY:    r_retry_lim <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_ring      = r_ring;
        n_last_seen = r_last_seen;
        n_last_plug = r_last_plug;
        n_link      = r_link;
        n_keep      = r_keep;
        n_retry     = r_retry;
        n_stop      = r_stop;
        n_cmd       = '0;
        n_out       = '0;

        if (r_in.req_type == REQ_PLUG) begin
            if (r_last_seen && (r_in.plugged == r_last_plug)) begin
                n_out.ignored = 1'b1;
            end else begin
                n_last_seen = 1'b1;
                n_last_plug = r_in.plugged;
                n_link      = r_in.plugged;
                if (!r_in.plugged && r_link) begin
                    n_ring = (r_ring == LAST_POS) ? '0 : r_ring + 1'b1;
                end
                if (!r_in.plugged) begin
                    n_retry            = '0;
                    n_cmd.wr           = 1'b1;
                    n_out.hold_awake   = r_quirks;
                    n_out.bounce_count = (cnt > CMP_W'(COUNT_MAX)) ? COUNT_MAX
                                                                  : cnt[COUNT_W-1:0];
                    if (r_in.cc_attached) begin
                        n_out.arm_timer = 1'b1;
                        if (cnt >= CMP_W'(r_level_2)) begin
                            n_keep                = !(cnt >= CMP_W'(r_level_3));
                            n_out.clear_history   = 1'b1;
                            n_out.fallback_action = FB_CLEAR;
                            n_out.report_error    = 1'b1;
                            if (r_quirks) begin
                                n_stop = STOP_ALL;
                                if (r_adsp) begin
                                    n_out.phy_action = PHY_OFF;
                                end
                            end
                        end else if (cnt >= CMP_W'(r_level_1)) begin
                            n_keep                = 1'b1;
                            n_out.fallback_action = FB_FORCE;
                            n_out.report_error    = 1'b1;
                            if (r_quirks) begin
                                n_stop = r_stop | STOP_PROTO;
                            end
                        end else begin
                            n_keep                = 1'b1;
                            n_out.fallback_action = FB_CLEAR;
                        end
                    end else begin
                        n_keep                = 1'b0;
                        n_out.clear_history   = 1'b1;
                        n_out.fallback_action = FB_CLEAR;
                        if (r_quirks) begin
                            n_stop    = STOP_NONE;
                            n_cmd.clr = 1'b1;
                            if (r_in.mmi_enabled && r_adsp) begin
                                n_out.phy_action = PHY_ON;
                            end
                        end
                    end
                end else begin
                    n_cmd.mark = 1'b1;
                end
            end
        end else if (!r_link) begin
            n_keep                = 1'b0;
            n_out.clear_history   = 1'b1;
            n_out.fallback_action = FB_CLEAR;
            n_out.notify_battery  = 1'b1;
            if (r_quirks) begin
                n_stop    = STOP_NONE;
                n_cmd.clr = 1'b1;
                if (r_in.mmi_enabled && r_adsp) begin
                    n_out.phy_action = PHY_ON;
                end
            end
            if (r_retry < r_retry_lim) begin
                n_retry          = r_retry + 1'b1;
                n_out.hold_awake = r_quirks;
                n_out.arm_timer  = 1'b1;
            end
        end

        n_out.link_hold  = n_keep & r_quirks;
        n_out.stop_flags = r_quirks ? n_stop : STOP_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_ring      <= '0;
            r_last_seen <= 1'b0;
            r_last_plug <= 1'b0;
            r_link      <= 1'b0;
            r_keep      <= 1'b0;
            r_retry     <= '0;
            r_stop      <= STOP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_in    <= i_in_item;
                        r_ref   <= TIME_BITS'(i_in_item.now) - TIME_BITS'(span);
                        r_step  <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_step != LAST_STEP) begin
                        r_step <= r_step + 1'b1;
                    end
                    if (commit) begin
                        r_ring      <= n_ring;
                        r_last_seen <= n_last_seen;
                        r_last_plug <= n_last_plug;
                        r_link      <= n_link;
                        r_keep      <= n_keep;
                        r_retry     <= n_retry;
                        r_stop      <= n_stop;
                        r_out       <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_ref       = r_ref;
    assign o_now       = TIME_BITS'(r_in.now);
    assign o_cmd       = commit ? n_cmd : '0;
    assign o_pos       = n_ring;

`ifndef SYNTH
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring <= LAST_POS)
        else $error("ring position out of range");

    a_start_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_EVAL) && (r_step == '0))
        else $error("accepted event did not start evaluation");

    a_ignored_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && n_out.ignored |-> (n_cmd == '0) && !n_out.arm_timer
            && (n_out.bounce_count == '0) && !n_out.clear_history)
        else $error("ignored event changed records or raised actions");

    a_count_quirks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.bounce_count != '0) |-> r_quirks)
        else $error("bounce count reported with quirks disabled");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (r_step == LAST_STEP) && !$isunknown(r_in.req_type))
        else $error("commit before the count chain settled");
`endif

endmodule

// ===== rtl/plug_bounce_quirk_monitor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plug_bounce_quirk_monitor_top
// Charger connection monitor with a ring of plug records held in a chain of
// cells; counts abnormal disconnects on plug-out and escalates.
//
//   channel   direction  handshake              payload
//   input     in         i_in_valid/o_in_ready   i_in_item  (t_in_item)
//   output    out        o_out_valid/i_out_ready o_out_item (t_out_item)
//   config    in         i_cfg_we                i_cfg_idx, i_cfg_data
//
// one event at a time; result registered when chain settles and output is free
// the partial count walks the cell chain one cell per cycle
// next event is taken as soon as the result is registered
// result waits in the output register while the next event evaluates
// synchronous active-low reset, records come up empty
// ----------------------------------------------------------------------------
module plug_bounce_quirk_monitor_top #(
    parameter int RECORDS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [pbqm_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pbqm_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pbqm_pkg::t_out_item        o_out_item
);
    import pbqm_pkg::*;

    localparam int POS_W = $clog2(RECORDS);
    localparam int CNT_W = $clog2(RECORDS + 1);

    logic [TIME_BITS-1:0] ref_time;
    logic [TIME_BITS-1:0] now_time;
    t_cell_cmd            cmd;
    logic [POS_W-1:0]     pos;
    logic [CNT_W-1:0]     sums [RECORDS+1];

    assign sums[0] = '0;

    pbqm_ctrl #(
        .RECORDS   (RECORDS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_chain_sum (sums[RECORDS]),
        .o_ref       (ref_time),
        .o_now       (now_time),
        .o_cmd       (cmd),
        .o_pos       (pos)
    );

    for (genvar g = 0; g < RECORDS; g++) begin : g_cell
        pbqm_cell #(
            .RECORDS   (RECORDS),
            .TIME_BITS (TIME_BITS),
            .IDX       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_pos   (pos),
            .i_ref   (ref_time),
            .i_now   (now_time),
            .i_sum   (sums[g]),
            .o_sum   (sums[g+1])
        );
    end

endmodule
